FILE: src/duff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Duffing oscillator step package
// Shared widths, reset values, codes and payload types of the oscillator block.
// ----------------------------------------------------------------------------
package duff_pkg;

   localparam int DATA_W      = 32;
   localparam int DT_W        = 17;
   localparam int UCOEF_W     = 31;
   localparam int OPER_W      = DATA_W + 1;
   localparam int PROD_W      = 2 * OPER_W;
   localparam int SUM_W       = DATA_W + 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

   // Quarter turn in Q30 and one in Q30, used to build the cosine table.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   localparam logic [DT_W-1:0]           STEP_DT_RESET   = 17'd655;
   localparam logic signed [DATA_W-1:0]  SPRING_K_RESET  = 32'sd0;
   localparam logic signed [DATA_W-1:0]  CUBIC_K_RESET   = 32'sd0;
   localparam logic [UCOEF_W-1:0]        DAMPING_C_RESET = 31'd196608;
   localparam logic [UCOEF_W-1:0]        INV_MASS_RESET  = 31'd65536;
   localparam logic signed [DATA_W-1:0]  FORCE_AMP_RESET = 32'sd26214400;
   localparam logic [UCOEF_W-1:0]        FORCE_FREQ_RESET = 31'd32768;

   typedef enum logic {
      OP_ADVANCE = 1'b0,
      OP_LOAD    = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      CSR_STEP_DT         = 3'd0,
      CSR_SPRING_K        = 3'd1,
      CSR_CUBIC_K         = 3'd2,
      CSR_DAMPING_C       = 3'd3,
      CSR_INV_MASS        = 3'd4,
      CSR_FORCE_AMPLITUDE = 3'd5,
      CSR_FORCE_FREQ      = 3'd6
   } csr_index_type;

   typedef enum logic {
      CMD_STEP = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PHASE,
      ST_DP,
      ST_X2,
      ST_LIN,
      ST_X3,
      ST_DMP,
      ST_CUB,
      ST_FRC,
      ST_FRC_WB,
      ST_ACC,
      ST_AM,
      ST_AM_WB,
      ST_DV,
      ST_DV_WB,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      MOP_NONE,
      MOP_PHASE,
      MOP_DP,
      MOP_X2,
      MOP_LIN,
      MOP_X3,
      MOP_DMP,
      MOP_CUB,
      MOP_FRC,
      MOP_AM,
      MOP_DV
   } mop_type;

   typedef struct packed {
      op_type                    operation;
      logic [DATA_W-1:0]         sim_time;
      logic signed [DATA_W-1:0]  load_position;
      logic signed [DATA_W-1:0]  load_velocity;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  position;
      logic signed [DATA_W-1:0]  velocity;
      logic                      saturated;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [DATA_W-1:0]         word_a;
      logic [DATA_W-1:0]         word_b;
   } cmd_type;

   typedef struct packed {
      logic [DT_W-1:0]           step_dt;
      logic signed [DATA_W-1:0]  spring_k;
      logic signed [DATA_W-1:0]  cubic_k;
      logic [UCOEF_W-1:0]        damping_c;
      logic [UCOEF_W-1:0]        inv_mass;
      logic signed [DATA_W-1:0]  force_amplitude;
      logic [UCOEF_W-1:0]        force_freq;
   } cfg_type;

   typedef struct packed {
      logic                      clip;
      logic signed [DATA_W-1:0]  value;
   } sat_type;

endpackage
`default_nettype wire

FILE: src/duffing_oscillator_euler_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Forced Duffing oscillator, explicit Euler step
// Keeps position and velocity in Q16.16 and advances them one step per step request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries a request: operation 0 advances one step at sim_time,
//   operation 1 loads load_position and load_velocity. Each request gives one
//   result on rsp_*: the new position, velocity and a saturation flag.
//   csr_* writes the step size and coefficients; write only while idle.
// Path: a request passes the front register and the queue; a step then runs
//   the full state schedule, while a load goes straight to the finish state.
// Sequencing: the sequencer takes a new request only when idle. A step
//   issues ten products in turn through one shared 33x33 multiplier, with
//   each dependent product waiting for the one before it to be scaled and
//   stored.
// Reset: position and velocity clear to zero, registers take their defaults,
//   the queue empties. No clearing pass is needed.
// Stall: a result waits in the output register while the next request runs.
//   The front register and a two-entry queue hold further requests; when they
//   are full, req_ready drops.
// ----------------------------------------------------------------------------
module duffing_oscillator_euler_step import duff_pkg::*; #(
   parameter int FRAC_BITS       = 16,
   parameter int COS_TABLE_DEPTH = 256
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire req_type        req_data,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output rsp_type             rsp_data,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire csr_index_type  csr_index,
   input  wire logic [31:0]    csr_data
);

   cfg_type cfg;
   logic    push_valid;
   logic    push_ready;
   cmd_type push_data;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_data;

   duff_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   duff_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   duff_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   duff_back #(
      .FRAC_BITS       (FRAC_BITS),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: src/duff_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Duffing oscillator configuration registers
// Holds the step size and model coefficients written through the CSR port.
// ----------------------------------------------------------------------------
module duff_csr import duff_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire csr_index_type  csr_index,
   input  wire logic [31:0]    csr_data,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STEP_DT:         cfg_in.step_dt         = csr_data[DT_W-1:0];
            CSR_SPRING_K:        cfg_in.spring_k        = $signed(csr_data);
            CSR_CUBIC_K:         cfg_in.cubic_k         = $signed(csr_data);
            CSR_DAMPING_C:       cfg_in.damping_c       = csr_data[UCOEF_W-1:0];
            CSR_INV_MASS:        cfg_in.inv_mass        = csr_data[UCOEF_W-1:0];
            CSR_FORCE_AMPLITUDE: cfg_in.force_amplitude = $signed(csr_data);
            CSR_FORCE_FREQ:      cfg_in.force_freq      = csr_data[UCOEF_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_dt         <= STEP_DT_RESET;
         cfg_ff.spring_k        <= SPRING_K_RESET;
         cfg_ff.cubic_k         <= CUBIC_K_RESET;
         cfg_ff.damping_c       <= DAMPING_C_RESET;
         cfg_ff.inv_mass        <= INV_MASS_RESET;
         cfg_ff.force_amplitude <= FORCE_AMP_RESET;
         cfg_ff.force_freq      <= FORCE_FREQ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/duff_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Duffing oscillator front end
// Registers each request and reduces it to a step or load command.
// ----------------------------------------------------------------------------
module duff_front import duff_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire req_type  req_data,
   output logic          push_valid,
   input  wire logic     push_ready,
   output cmd_type       push_data
);

   logic    hold_valid_ff;
   logic    hold_valid_in;
   cmd_type hold_ff;
   cmd_type hold_in;
   logic    accept;

   assign req_ready  = !hold_valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = hold_valid_ff;
   assign push_data  = hold_ff;

   // A step only needs the time; a load carries the new state.
   always_comb begin
      hold_in = hold_ff;
      if (accept) begin
         case (req_data.operation)
            OP_LOAD: begin
               hold_in.kind   = CMD_LOAD;
               hold_in.word_a = req_data.load_position;
               hold_in.word_b = req_data.load_velocity;
            end
            default: begin
               hold_in.kind   = CMD_STEP;
               hold_in.word_a = req_data.sim_time;
               hold_in.word_b = '0;
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule
`default_nettype wire

FILE: src/duff_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Duffing oscillator command queue
// Short FIFO that decouples the front end from the step sequencer.
// ----------------------------------------------------------------------------
module duff_queue import duff_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   output logic          push_ready,
   input  wire cmd_type  push_data,
   output logic          pop_valid,
   input  wire logic     pop_ready,
   output cmd_type       pop_data
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: src/duff_cos_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Duffing oscillator cosine table
// Quarter-wave cosine table built at elaboration with integer Taylor terms.
// ----------------------------------------------------------------------------
module duff_cos_rom import duff_pkg::*; #(
   parameter int FRAC_BITS       = 16,
   parameter int COS_TABLE_DEPTH = 256
) (
   input  wire logic [$clog2(COS_TABLE_DEPTH)-1:0] rom_index,
   output logic [FRAC_BITS:0]                      rom_entry
);

   // cos(pi/2 * i / depth) by a seven-term Horner series in Q30, then rounded.
   function automatic logic [FRAC_BITS:0] cos_entry(input int unsigned idx);
      logic [63:0] ang;
      logic [63:0] y;
      logic [63:0] t;
      logic [63:0] s;
      ang = (HALF_PI_Q30 * 64'(idx)) / COS_TABLE_DEPTH;
      y   = (ang * ang) >> 30;
      t   = ONE_Q30;
      s   = ((y * t) >> 30) / 64'd132;
      t   = (s > ONE_Q30) ? 64'd0 : ONE_Q30 - s;
      s   = ((y * t) >> 30) / 64'd90;
      t   = (s > ONE_Q30) ? 64'd0 : ONE_Q30 - s;
      s   = ((y * t) >> 30) / 64'd56;
      t   = (s > ONE_Q30) ? 64'd0 : ONE_Q30 - s;
      s   = ((y * t) >> 30) / 64'd30;
      t   = (s > ONE_Q30) ? 64'd0 : ONE_Q30 - s;
      s   = ((y * t) >> 30) / 64'd12;
      t   = (s > ONE_Q30) ? 64'd0 : ONE_Q30 - s;
      s   = ((y * t) >> 30) / 64'd2;
      t   = (s > ONE_Q30) ? 64'd0 : ONE_Q30 - s;
      t   = (t + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      return t[FRAC_BITS:0];
   endfunction

   logic [FRAC_BITS:0] rom_tab [COS_TABLE_DEPTH];

   for (genvar i = 0; i < COS_TABLE_DEPTH; i++) begin : g_tab
      localparam logic [FRAC_BITS:0] ENTRY = cos_entry(i);
      assign rom_tab[i] = ENTRY;
   end

   assign rom_entry = rom_tab[rom_index];

endmodule
`default_nettype wire

FILE: src/duff_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Duffing oscillator step sequencer
// Runs each Euler step on a shared multiplier, applies loads, and holds the oscillator state.
// ----------------------------------------------------------------------------
module duff_back import duff_pkg::*; #(
   parameter int FRAC_BITS       = 16,
   parameter int COS_TABLE_DEPTH = 256
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     pop_valid,
   output logic          pop_ready,
   input  wire cmd_type  pop_data,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   localparam int ROM_AW  = $clog2(COS_TABLE_DEPTH);
   localparam int PHASE_W = ROM_AW + 2;
   localparam int COS_W   = FRAC_BITS + 2;

   state_type                 state_ff;
   state_type                 state_in;
   mop_type                   mop_ff;
   mop_type                   mop_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [OPER_W-1:0]  mul_a;
   logic signed [OPER_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  mul_res;

   logic [DATA_W-1:0]         time_ff;
   logic [DATA_W-1:0]         time_in;
   logic signed [COS_W-1:0]   cos_ff;
   logic signed [COS_W-1:0]   cos_in;
   logic signed [DATA_W-1:0]  nx_ff;
   logic signed [DATA_W-1:0]  nx_in;
   logic signed [DATA_W-1:0]  nv_ff;
   logic signed [DATA_W-1:0]  nv_in;
   logic signed [DATA_W-1:0]  xp_ff;
   logic signed [DATA_W-1:0]  xp_in;
   logic signed [DATA_W-1:0]  lin_ff;
   logic signed [DATA_W-1:0]  lin_in;
   logic signed [DATA_W-1:0]  cub_ff;
   logic signed [DATA_W-1:0]  cub_in;
   logic signed [DATA_W-1:0]  dmp_ff;
   logic signed [DATA_W-1:0]  dmp_in;
   logic signed [DATA_W-1:0]  frc_ff;
   logic signed [DATA_W-1:0]  frc_in;
   logic signed [DATA_W-1:0]  acc_ff;
   logic signed [DATA_W-1:0]  acc_in;
   logic                      flag_ff;
   logic                      flag_in;
   logic signed [DATA_W-1:0]  pos_ff;
   logic signed [DATA_W-1:0]  pos_in;
   logic signed [DATA_W-1:0]  vel_ff;
   logic signed [DATA_W-1:0]  vel_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;

   logic                      slot_free;
   logic                      cubic_on;
   logic signed [PROD_W-1:0]  prod_shift;
   sat_type                   scaled;
   logic signed [SUM_W-1:0]   sum;
   sat_type                   sum_sat;

   logic [PHASE_W-1:0]        phase;
   logic [1:0]                quadrant;
   logic [ROM_AW:0]           rom_sel;
   logic [ROM_AW-1:0]         rom_index;
   logic [FRAC_BITS:0]        rom_entry;
   logic [FRAC_BITS:0]        cos_mag;

   // Clip a wide signed value to the 32-bit range and report the clip.
   function automatic sat_type clip_wide(input logic signed [PROD_W-1:0] v);
      sat_type                     r;
      logic [PROD_W-DATA_W:0]      hi;
      hi = v[PROD_W-1:DATA_W-1];
      if (&hi || ~|hi) begin
         r.clip  = 1'b0;
         r.value = v[DATA_W-1:0];
      end else begin
         r.clip  = 1'b1;
         r.value = v[PROD_W-1] ? DATA_MIN : DATA_MAX;
      end
      return r;
   endfunction

   duff_cos_rom #(
      .FRAC_BITS       (FRAC_BITS),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_cos_rom (
      .rom_index (rom_index),
      .rom_entry (rom_entry)
   );

   assign pop_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cubic_on  = (cfg.cubic_k != '0);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next state: a fixed schedule for a step, a short path for a load.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = (pop_data.kind == CMD_LOAD) ? ST_FINISH : ST_PHASE;
            end
         end
         ST_PHASE:  state_in = ST_DP;
         ST_DP:     state_in = ST_X2;
         ST_X2:     state_in = ST_LIN;
         ST_LIN:    state_in = ST_X3;
         ST_X3:     state_in = ST_DMP;
         ST_DMP:    state_in = ST_CUB;
         ST_CUB:    state_in = ST_FRC;
         ST_FRC:    state_in = ST_FRC_WB;
         ST_FRC_WB: state_in = ST_ACC;
         ST_ACC:    state_in = ST_AM;
         ST_AM:     state_in = ST_AM_WB;
         ST_AM_WB:  state_in = ST_DV;
         ST_DV:     state_in = ST_DV_WB;
         ST_DV_WB:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Multiplier issue: operands for the product formed in this state.
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mop_in = MOP_NONE;
      case (state_ff)
         ST_PHASE: begin
            mul_a  = {2'b00, cfg.force_freq};
            mul_b  = {1'b0, time_ff};
            mop_in = MOP_PHASE;
         end
         ST_DP: begin
            mul_a  = {{(OPER_W-DT_W){1'b0}}, cfg.step_dt};
            mul_b  = OPER_W'(vel_ff);
            mop_in = MOP_DP;
         end
         ST_X2: begin
            mul_a  = OPER_W'(pos_ff);
            mul_b  = OPER_W'(pos_ff);
            mop_in = MOP_X2;
         end
         ST_LIN: begin
            mul_a  = OPER_W'(cfg.spring_k);
            mul_b  = OPER_W'(pos_ff);
            mop_in = MOP_LIN;
         end
         ST_X3: begin
            mul_a  = OPER_W'(xp_ff);
            mul_b  = OPER_W'(pos_ff);
            mop_in = MOP_X3;
         end
         ST_DMP: begin
            mul_a  = {2'b00, cfg.damping_c};
            mul_b  = OPER_W'(vel_ff);
            mop_in = MOP_DMP;
         end
         ST_CUB: begin
            mul_a  = OPER_W'(cfg.cubic_k);
            mul_b  = OPER_W'(xp_ff);
            mop_in = MOP_CUB;
         end
         ST_FRC: begin
            mul_a  = OPER_W'(cfg.force_amplitude);
            mul_b  = OPER_W'(cos_ff);
            mop_in = MOP_FRC;
         end
         ST_AM: begin
            mul_a  = OPER_W'(acc_ff);
            mul_b  = {2'b00, cfg.inv_mass};
            mop_in = MOP_AM;
         end
         ST_DV: begin
            mul_a  = {{(OPER_W-DT_W){1'b0}}, cfg.step_dt};
            mul_b  = OPER_W'(acc_ff);
            mop_in = MOP_DV;
         end
         default: begin
            mul_a  = '0;
            mul_b  = '0;
            mop_in = MOP_NONE;
         end
      endcase
   end

   assign mul_res = mul_a * mul_b;

   // Fixed-point scaling floors toward minus infinity, then clips.
   assign prod_shift = prod_ff >>> FRAC_BITS;
   assign scaled     = clip_wide(prod_shift);

   // The fractional turn picks a quadrant and a table entry; odd quadrants
   // read the table mirrored, where the mirror of entry zero is cos(pi/2) = 0.
   assign phase     = prod_ff[2*FRAC_BITS-1 -: PHASE_W];
   assign quadrant  = phase[PHASE_W-1 -: 2];
   assign rom_sel   = quadrant[0]
                      ? (ROM_AW+1)'(COS_TABLE_DEPTH) - {1'b0, phase[ROM_AW-1:0]}
                      : {1'b0, phase[ROM_AW-1:0]};
   assign rom_index = rom_sel[ROM_AW-1:0];
   assign cos_mag   = rom_sel[ROM_AW] ? '0 : rom_entry;

   always_comb begin
      cos_in  = cos_ff;
      time_in = time_ff;
      nx_in   = nx_ff;
      nv_in   = nv_ff;
      xp_in   = xp_ff;
      lin_in  = lin_ff;
      cub_in  = cub_ff;
      dmp_in  = dmp_ff;
      frc_in  = frc_ff;
      acc_in  = acc_ff;
      flag_in = flag_ff;
      pos_in  = pos_ff;
      vel_in  = vel_ff;
      rsp_in  = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sum     = '0;

      // Write back the product issued in the previous cycle.
      case (mop_ff)
         MOP_PHASE: begin
            cos_in = (quadrant[0] ^ quadrant[1]) ? -$signed({1'b0, cos_mag})
                                                 : $signed({1'b0, cos_mag});
         end
         MOP_DP: begin
            sum     = SUM_W'(pos_ff) + SUM_W'(scaled.value);
            nx_in   = sum_sat.value;
            flag_in = flag_ff || scaled.clip || sum_sat.clip;
         end
         MOP_X2: begin
            xp_in   = scaled.value;
            flag_in = flag_ff || (scaled.clip && cubic_on);
         end
         MOP_LIN: begin
            lin_in  = scaled.value;
            flag_in = flag_ff || scaled.clip;
         end
         MOP_X3: begin
            xp_in   = scaled.value;
            flag_in = flag_ff || (scaled.clip && cubic_on);
         end
         MOP_DMP: begin
            dmp_in  = scaled.value;
            flag_in = flag_ff || scaled.clip;
         end
         MOP_CUB: begin
            cub_in  = scaled.value;
            flag_in = flag_ff || (scaled.clip && cubic_on);
         end
         MOP_FRC: begin
            frc_in  = scaled.value;
            flag_in = flag_ff || scaled.clip;
         end
         MOP_AM: begin
            acc_in  = scaled.value;
            flag_in = flag_ff || scaled.clip;
         end
         MOP_DV: begin
            sum     = SUM_W'(vel_ff) + SUM_W'(scaled.value);
            nv_in   = sum_sat.value;
            flag_in = flag_ff || scaled.clip || sum_sat.clip;
         end
         default: begin
            cos_in = cos_ff;
         end
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               flag_in = 1'b0;
               time_in = pop_data.word_a;
               nx_in   = $signed(pop_data.word_a);
               nv_in   = $signed(pop_data.word_b);
            end
         end
         ST_ACC: begin
            sum     = SUM_W'(frc_ff) - SUM_W'(lin_ff) - SUM_W'(cub_ff) - SUM_W'(dmp_ff);
            acc_in  = sum_sat.value;
            flag_in = flag_ff || sum_sat.clip;
         end
         ST_FINISH: begin
            if (slot_free) begin
               pos_in             = nx_ff;
               vel_in             = nv_ff;
               rsp_in.position    = nx_ff;
               rsp_in.velocity    = nv_ff;
               rsp_in.saturated   = flag_ff;
               rsp_valid_in       = 1'b1;
            end
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
   end

   assign sum_sat = clip_wide(PROD_W'(sum));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mop_ff       <= MOP_NONE;
         pos_ff       <= '0;
         vel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mop_ff       <= mop_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_res;
      time_ff <= time_in;
      cos_ff  <= cos_in;
      nx_ff   <= nx_in;
      nv_ff   <= nv_in;
      xp_ff   <= xp_in;
      lin_ff  <= lin_in;
      cub_ff  <= cub_in;
      dmp_ff  <= dmp_in;
      frc_ff  <= frc_in;
      acc_ff  <= acc_in;
      flag_ff <= flag_in;
      rsp_ff  <= rsp_in;
   end

endmodule
`default_nettype wire

FILE: src/duff_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Duffing oscillator port checker
// Watches the top-level ports for lost, invented or unstable results.
// ----------------------------------------------------------------------------
module duff_checker import duff_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_ready,
   input  wire logic     rsp_valid,
   input  wire logic     rsp_ready,
   input  wire rsp_type  rsp_data,
   input  wire logic     csr_ready
);

   // Front register, two queue entries, one item in work, one output register.
   localparam logic [2:0] MAX_OUTSTANDING = 3'd5;

   logic [2:0] outstanding_ff;
   logic [2:0] outstanding_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_fire && !rsp_fire) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready && csr_ready)
      else $error("block not empty after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 3'd0)
      else $error("result without a pending request");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= MAX_OUTSTANDING)
      else $error("more requests in flight than the block can hold");

endmodule

bind duffing_oscillator_euler_step duff_checker u_checker (.*);
`default_nettype wire

FILE: tb/duffing_oscillator_euler_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duffing oscillator Euler step testbench
// Drives load and advance requests through the valid/ready channels, and
// rewrites the coefficient registers between phases while the block is idle.
// Results are checked field by field against a fixed-point model or typed values.
// ----------------------------------------------------------------------------
module duffing_oscillator_euler_step_tb;
   import duff_pkg::*;

   localparam int FRAC_BITS       = 16;
   localparam int COS_DEPTH       = 256;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int RUN_LIMIT_NS    = 2_000_000;

   localparam csr_index_type CSR_UNUSED = csr_index_type'(3'd7);

   typedef enum {SET_TYPICAL, SET_HIGH, SET_LOW, SET_RANDOM} setting_type;

   typedef struct {
      bit            is_write;
      csr_index_type reg_index;
      logic [31:0]   reg_value;
      req_type       request;
      bit            typed;
      rsp_type       typed_result;
   } stim_row_type;

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_STEP_DT;
   logic [31:0]   csr_data = '0;

   // Intended levels of the two valids, so each is assigned at most once a step.
   bit req_on = 1'b0;
   bit csr_on = 1'b0;

   bit hold_go = 1'b0;
   bit hold_rsp = 1'b0;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;

   // Model of the oscillator: coefficients, state and the cosine table.
   cfg_type                  osc_cfg;
   logic signed [DATA_W-1:0] osc_pos;
   logic signed [DATA_W-1:0] osc_vel;
   bit                       step_clip;
   longint                   cos_tab [COS_DEPTH];
   logic [31:0]              run_time = '0;

   rsp_type      expected_states [$];
   stim_row_type directed_rows [$];

   int mismatch_count = 0;
   int results_checked = 0;
   int requests_sent = 0;
   int loads_sent = 0;
   int clipped_expected = 0;
   int csr_writes = 0;
   int settings_used = 0;

   duffing_oscillator_euler_step u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Fixed-point model
   // ------------------------------------------------------------------------
   function automatic logic signed [DATA_W-1:0] clip_q16(input longint v);
      if (v > longint'(DATA_MAX)) begin
         step_clip = 1'b1;
         return DATA_MAX;
      end
      if (v < longint'(DATA_MIN)) begin
         step_clip = 1'b1;
         return DATA_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

   // Arithmetic shift of the exact product rounds toward minus infinity.
   function automatic logic signed [DATA_W-1:0] mul_q16(input longint a, input longint b);
      return clip_q16((a * b) >>> FRAC_BITS);
   endfunction

   function automatic void build_cosine_table();
      logic [63:0] ang, y, t, s, d;
      for (int i = 0; i < COS_DEPTH; i++) begin
         ang = (HALF_PI_Q30 * 64'(i)) / COS_DEPTH;
         y = (ang * ang) >> 30;
         t = ONE_Q30;
         // Taylor series of the cosine, evaluated from the highest term down.
         for (int n = 6; n >= 1; n--) begin
            d = 64'((2 * n - 1) * (2 * n));
            s = ((y * t) >> 30) / d;
            t = (s > ONE_Q30) ? 64'd0 : ONE_Q30 - s;
         end
         cos_tab[i] = longint'((t + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
      end
   endfunction

   function automatic longint cosine_at(input logic [31:0] t);
      logic [63:0] turn, idx, quad, r;
      turn = (64'(osc_cfg.force_freq) * 64'(t)) & ((64'd1 << (2 * FRAC_BITS)) - 1);
      idx = (turn * (4 * COS_DEPTH)) >> (2 * FRAC_BITS);
      quad = (idx / COS_DEPTH) % 4;
      r = idx % COS_DEPTH;
      case (quad)
         0: return cos_tab[r];
         1: return (r == 0) ? 0 : -cos_tab[COS_DEPTH - r];
         2: return -cos_tab[r];
         default: return (r == 0) ? 0 : cos_tab[COS_DEPTH - r];
      endcase
   endfunction

   function automatic void reset_oscillator();
      osc_cfg.step_dt         = STEP_DT_RESET;
      osc_cfg.spring_k        = SPRING_K_RESET;
      osc_cfg.cubic_k         = CUBIC_K_RESET;
      osc_cfg.damping_c       = DAMPING_C_RESET;
      osc_cfg.inv_mass        = INV_MASS_RESET;
      osc_cfg.force_amplitude = FORCE_AMP_RESET;
      osc_cfg.force_freq      = FORCE_FREQ_RESET;
      osc_pos = '0;
      osc_vel = '0;
      build_cosine_table();
   endfunction

   function automatic void set_coefficient(input csr_index_type idx, input logic [31:0] data);
      case (idx)
         CSR_STEP_DT:         osc_cfg.step_dt = data[DT_W-1:0];
         CSR_SPRING_K:        osc_cfg.spring_k = data;
         CSR_CUBIC_K:         osc_cfg.cubic_k = data;
         CSR_DAMPING_C:       osc_cfg.damping_c = data[UCOEF_W-1:0];
         CSR_INV_MASS:        osc_cfg.inv_mass = data[UCOEF_W-1:0];
         CSR_FORCE_AMPLITUDE: osc_cfg.force_amplitude = data;
         CSR_FORCE_FREQ:      osc_cfg.force_freq = data[UCOEF_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic rsp_type advance_oscillator(input req_type r);
      rsp_type                  o;
      longint                   dp, x2, x3, cub, lin, dmp, frc, acc, am, dv;
      logic signed [DATA_W-1:0] nx, nv;
      step_clip = 1'b0;
      if (r.operation == OP_LOAD) begin
         nx = r.load_position;
         nv = r.load_velocity;
      end else begin
         dp = mul_q16(osc_cfg.step_dt, osc_vel);
         nx = clip_q16(longint'(osc_pos) + dp);
         cub = 0;
         // The linear model skips the cubic chain, so it cannot clip there.
         if (osc_cfg.cubic_k != 0) begin
            x2 = mul_q16(osc_pos, osc_pos);
            x3 = mul_q16(x2, osc_pos);
            cub = mul_q16(osc_cfg.cubic_k, x3);
         end
         lin = mul_q16(osc_cfg.spring_k, osc_pos);
         dmp = mul_q16(osc_cfg.damping_c, osc_vel);
         frc = mul_q16(osc_cfg.force_amplitude, cosine_at(r.sim_time));
         acc = clip_q16(frc - lin - cub - dmp);
         am = mul_q16(acc, osc_cfg.inv_mass);
         dv = mul_q16(osc_cfg.step_dt, am);
         nv = clip_q16(longint'(osc_vel) + dv);
      end
      osc_pos = nx;
      osc_vel = nv;
      o.position = nx;
      o.velocity = nv;
      o.saturated = step_clip;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Request and register channels
   // ------------------------------------------------------------------------
   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_result);
      rsp_type predicted;
      if (csr_on) begin
         csr_valid <= 1'b0;
         csr_on = 1'b0;
      end
      if ($urandom_range(99) < send_idle_pct) begin
         if (req_on) begin
            req_valid <= 1'b0;
            req_on = 1'b0;
         end
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_on = 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predicted = advance_oscillator(r);
      expected_states.push_back(typed ? typed_result : predicted);
      requests_sent++;
      if (r.operation == OP_LOAD) loads_sent++;
      if (predicted.saturated) clipped_expected++;
   endtask

   // Registers change only once every outstanding request has returned.
   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      if (req_on) begin
         req_valid <= 1'b0;
         req_on = 1'b0;
      end
      while (expected_states.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_on = 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      set_coefficient(idx, data);
      csr_writes++;
   endtask

   task automatic apply_settings(input setting_type kind);
      logic [31:0] dt, spring, cubic, damp, imass, amp, freq;
      case (kind)
         SET_HIGH: begin
            dt = 32'd65536;
            spring = DATA_MAX;
            cubic = DATA_MAX;
            damp = 32'h7FFF_FFFF;
            imass = 32'h7FFF_FFFF;
            amp = DATA_MAX;
            freq = 32'h7FFF_FFFF;
         end
         SET_LOW: begin
            dt = '0;
            spring = DATA_MIN;
            cubic = DATA_MIN;
            damp = '0;
            imass = 32'd1;
            amp = DATA_MIN;
            freq = '0;
         end
         SET_RANDOM: begin
            dt = $urandom();
            spring = $urandom();
            cubic = $urandom();
            damp = $urandom();
            imass = $urandom();
            amp = $urandom();
            freq = $urandom();
         end
         default: begin
            dt = $urandom_range(2000);
            spring = $urandom_range(32'h0010_0000) - 32'h0008_0000;
            cubic = ($urandom_range(1) == 0) ? 32'd0
                                             : $urandom_range(32'h0004_0000) - 32'h0002_0000;
            damp = $urandom_range(32'h0008_0000);
            imass = $urandom_range(32'h0002_0000);
            amp = $urandom_range(32'h0800_0000) - 32'h0400_0000;
            freq = $urandom_range(32'h0004_0000);
         end
      endcase
      write_csr(CSR_STEP_DT, dt);
      write_csr(CSR_SPRING_K, spring);
      write_csr(CSR_CUBIC_K, cubic);
      write_csr(CSR_DAMPING_C, damp);
      write_csr(CSR_INV_MASS, imass);
      write_csr(CSR_FORCE_AMPLITUDE, amp);
      write_csr(CSR_FORCE_FREQ, freq);
      settings_used++;
   endtask

   // Mostly advances along a running time axis, with jumps and a few loads.
   function automatic req_type random_request();
      req_type r;
      r.operation = ($urandom_range(9) == 0) ? OP_LOAD : OP_ADVANCE;
      if ($urandom_range(3) == 0) run_time = $urandom();
      else run_time += 32'(osc_cfg.step_dt);
      r.sim_time = run_time;
      if ($urandom_range(1) == 0) begin
         r.load_position = $urandom();
         r.load_velocity = $urandom();
      end else begin
         r.load_position = $urandom_range(32'h0080_0000) - 32'h0040_0000;
         r.load_velocity = $urandom_range(32'h0080_0000) - 32'h0040_0000;
      end
      return r;
   endfunction

   function automatic void add_request(input op_type op, input logic [31:0] t,
                                       input logic [31:0] lp, input logic [31:0] lv,
                                       input bit typed, input rsp_type want);
      stim_row_type row;
      row.is_write = 1'b0;
      row.reg_index = CSR_STEP_DT;
      row.reg_value = '0;
      row.request.operation = op;
      row.request.sim_time = t;
      row.request.load_position = lp;
      row.request.load_velocity = lv;
      row.typed = typed;
      row.typed_result = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(input csr_index_type idx, input logic [31:0] data);
      stim_row_type row;
      row.is_write = 1'b1;
      row.reg_index = idx;
      row.reg_value = data;
      row.request = '0;
      row.typed = 1'b0;
      row.typed_result = '0;
      directed_rows.push_back(row);
   endfunction

   // ------------------------------------------------------------------------
   // Result channel
   // ------------------------------------------------------------------------
   function automatic void report_mismatch(input string what, input logic [31:0] want,
                                           input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("Mismatch on %s at %0t ns: expected %h, got %h", what, $time, want, got);
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_states.size() == 0) begin
         report_mismatch("result with no request outstanding", '0, got.position);
         return;
      end
      want = expected_states.pop_front();
      if (got.position !== want.position) report_mismatch("position", want.position, got.position);
      if (got.velocity !== want.velocity) report_mismatch("velocity", want.velocity, got.velocity);
      if (got.saturated !== want.saturated)
         report_mismatch("saturated", 32'(want.saturated), 32'(got.saturated));
      results_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         rsp_ready <= !hold_rsp && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // A long hold on the result side, so the request side backs up and stalls.
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      setting_type kind;
      reset_oscillator();

      // With the reset coefficients, one step from rest at time zero gives
      // v = dt * 400.0, that is 655 * 400.
      add_request(OP_ADVANCE, 32'd0, 32'd0, 32'd0, 1'b1, rsp_type'{32'sd0, 32'sd262000, 1'b0});
      add_request(OP_LOAD, 32'hFFFF_FFFF, DATA_MAX, DATA_MAX, 1'b1,
                  rsp_type'{DATA_MAX, DATA_MAX, 1'b0});
      add_request(OP_ADVANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
      add_request(OP_LOAD, 32'd0, DATA_MIN, DATA_MIN, 1'b1, rsp_type'{DATA_MIN, DATA_MIN, 1'b0});
      add_request(OP_ADVANCE, 32'h0000_4000, 32'd0, 32'd0, 1'b0, '0);
      add_request(OP_LOAD, 32'h0000_1234, 32'h0002_0000, 32'hFFFF_0000, 1'b1,
                  rsp_type'{32'sh0002_0000, 32'shFFFF_0000, 1'b0});
      // Quadrant boundaries of the cosine at the default half-turn frequency.
      add_request(OP_ADVANCE, 32'h0000_8000, 32'd0, 32'd0, 1'b0, '0);
      add_request(OP_ADVANCE, 32'h0001_0000, 32'd0, 32'd0, 1'b0, '0);
      add_request(OP_ADVANCE, 32'h0001_8000, 32'd0, 32'd0, 1'b0, '0);
      add_write(CSR_CUBIC_K, 32'h0001_0000);
      add_write(CSR_SPRING_K, 32'hFFFF_0000);
      add_request(OP_LOAD, 32'd0, 32'h0003_0000, 32'd0, 1'b1,
                  rsp_type'{32'sh0003_0000, 32'sd0, 1'b0});
      add_request(OP_ADVANCE, 32'h0000_1234, 32'd0, 32'd0, 1'b0, '0);
      // A position of 256.0 overflows its own square in the cubic chain.
      add_request(OP_LOAD, 32'd0, 32'h0100_0000, 32'd0, 1'b1,
                  rsp_type'{32'sh0100_0000, 32'sd0, 1'b0});
      add_request(OP_ADVANCE, 32'h0002_0000, 32'd0, 32'd0, 1'b0, '0);
      add_write(CSR_INV_MASS, 32'd0);
      add_request(OP_ADVANCE, 32'h0002_4000, 32'd0, 32'd0, 1'b0, '0);
      add_write(CSR_STEP_DT, 32'd65536);
      add_write(CSR_CUBIC_K, DATA_MIN);
      add_write(CSR_DAMPING_C, 32'h7FFF_FFFF);
      add_write(CSR_INV_MASS, 32'h7FFF_FFFF);
      add_write(CSR_FORCE_AMPLITUDE, DATA_MIN);
      add_write(CSR_FORCE_FREQ, 32'h7FFF_FFFF);
      add_write(CSR_UNUSED, 32'hFFFF_FFFF);
      add_request(OP_LOAD, 32'd0, DATA_MAX, DATA_MIN, 1'b1, rsp_type'{DATA_MAX, DATA_MIN, 1'b0});
      add_request(OP_ADVANCE, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0, '0);
      add_request(OP_ADVANCE, 32'd0, 32'd0, 32'd0, 1'b0, '0);

      send_idle_pct = 23;
      rsp_idle_pct = 56;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write)
            write_csr(directed_rows[i].reg_index, directed_rows[i].reg_value);
         else
            send_request(directed_rows[i].request, directed_rows[i].typed,
                         directed_rows[i].typed_result);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 23;
            rsp_idle_pct = 56;
         end else if (phase < 6) begin
            send_idle_pct = 56;
            rsp_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (phase == 2) kind = SET_HIGH;
         else if (phase == 5) kind = SET_LOW;
         else kind = ($urandom_range(3) == 0) ? SET_RANDOM : SET_TYPICAL;
         apply_settings(kind);
         if (phase == 4) hold_go = 1'b1;
         repeat (ITEMS_PER_PHASE) send_request(random_request(), 1'b0, '0);
      end

      if (req_on) begin
         req_valid <= 1'b0;
         req_on = 1'b0;
      end
      if (csr_on) begin
         csr_valid <= 1'b0;
         csr_on = 1'b0;
      end
      while (expected_states.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests (%0d loads) and %0d register writes across %0d settings.",
               requests_sent, loads_sent, csr_writes, settings_used + 1);
      $display("Compared %0d results, %0d of them with clipping expected; %0d mismatches.",
               results_checked, clipped_expected, mismatch_count);
      if (mismatch_count == 0 && expected_states.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
src/duff_pkg.sv
src/duff_csr.sv
src/duff_front.sv
src/duff_queue.sv
src/duff_cos_rom.sv
src/duff_back.sv
src/duffing_oscillator_euler_step.sv
src/duff_checker.sv
tb/duffing_oscillator_euler_step_tb.sv
